### hdl/brf_pkg.sv
// shared constants, types and field layout for the battery report filter
package brf_pkg;

    // field widths
    localparam int PCT_W  = 7;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    // stream data widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PCT_THRESHOLD   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_INTERVAL_MS = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEARTBEAT_MS    = 2'd2;

    // configuration reset values
    localparam logic [PCT_W-1:0]  PCT_THRESHOLD_RST   = 7'd5;
    localparam logic [TIME_W-1:0] MIN_INTERVAL_MS_RST = 32'd60000;
    localparam logic [TIME_W-1:0] HEARTBEAT_MS_RST    = 32'd600000;

    // why the percentage is reported
    typedef enum logic [1:0] {
        REASON_NONE      = 2'd0,
        REASON_FIRST     = 2'd1,
        REASON_HEARTBEAT = 2'd2,
        REASON_CHANGE    = 2'd3
    } reason_t;

    // one result, fields listed from the highest bit down
    typedef struct packed {
        logic [3:0]       pad;
        reason_t          report_reason;
        logic [PCT_W-1:0] pct_value;
        logic             pct_report;
        logic             charge_value;
        logic             charge_report;
    } result_t;

endpackage

### hdl/battery_report_filter_core.sv
// battery report filter top level: input register, report decision, result register
//
// Each poll sample (percent, charging flag, millisecond time) produces exactly one
// result. The charging flag is reported on the first sample and on every change.
// The percentage is reported on the first sample, when heartbeat_ms have passed
// since the last percentage report, or when it moved by at least pct_threshold
// from the last reported value and min_interval_ms have passed; elapsed time is
// the wrapping 32-bit difference. A sample is taken every cycle unless m_tready
// holds back a full result register; each sample passes the input register and
// then the result register. The filter state is updated in the cycle a sample
// moves into the result register, so back-to-back samples see the state left by
// the one before. The user writes configuration via cfg_wr_en, cfg_index, cfg_wdata
// only while no sample is in flight, not enforced by the block; index 3 is ignored.
module battery_report_filter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input sample: percent[6:0], charging[7], now_ms[39:8]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [brf_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result: charge_report[0], charge_value[1], pct_report[2],
    // pct_value[9:3], report_reason[11:10], zeros[15:12]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [brf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [brf_pkg::IDX_W-1:0]        cfg_index,
    input  logic [brf_pkg::CFG_W-1:0]        cfg_wdata
);
    import brf_pkg::*;

    // configuration registers
    logic [PCT_W-1:0]  pct_threshold_reg;
    logic [TIME_W-1:0] min_interval_ms_reg;
    logic [TIME_W-1:0] heartbeat_ms_reg;

    // input register
    logic              in_valid_reg;
    logic [PCT_W-1:0]  in_percent_reg;
    logic              in_charging_reg;
    logic [TIME_W-1:0] in_now_reg;

    // filter state
    logic [PCT_W-1:0]  last_percent_reg;
    logic              percent_seen_reg;
    logic              last_charging_reg;
    logic              charging_seen_reg;
    logic [TIME_W-1:0] last_report_time_reg;

    // result register
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result_next;

    // handshake
    logic              s_xfer;
    logic              out_free;
    logic              advance;

    // decision
    logic              charge_change;
    logic [PCT_W-1:0]  pct_diff;
    logic [TIME_W-1:0] since;
    reason_t           reason;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // report decision for the sample in the input register
    always_comb begin
        charge_change = !charging_seen_reg || (in_charging_reg != last_charging_reg);
        pct_diff = (in_percent_reg >= last_percent_reg) ?
                   (in_percent_reg - last_percent_reg) :
                   (last_percent_reg - in_percent_reg);
        since = in_now_reg - last_report_time_reg;
        if (!percent_seen_reg) begin
            reason = REASON_FIRST;
        end else if (since >= heartbeat_ms_reg) begin
            reason = REASON_HEARTBEAT;
        end else if (pct_diff >= pct_threshold_reg && since >= min_interval_ms_reg) begin
            reason = REASON_CHANGE;
        end else begin
            reason = REASON_NONE;
        end
        result_next               = '0;
        result_next.charge_report = charge_change;
        result_next.charge_value  = charge_change & in_charging_reg;
        result_next.pct_report    = (reason != REASON_NONE);
        result_next.pct_value     = (reason != REASON_NONE) ? in_percent_reg : '0;
        result_next.report_reason = reason;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_threshold_reg   <= PCT_THRESHOLD_RST;
            min_interval_ms_reg <= MIN_INTERVAL_MS_RST;
            heartbeat_ms_reg    <= HEARTBEAT_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PCT_THRESHOLD:   pct_threshold_reg   <= cfg_wdata[PCT_W-1:0];
                REG_MIN_INTERVAL_MS: min_interval_ms_reg <= cfg_wdata[TIME_W-1:0];
                REG_HEARTBEAT_MS:    heartbeat_ms_reg    <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_xfer) begin
            in_percent_reg  <= s_tdata[PCT_W-1:0];
            in_charging_reg <= s_tdata[PCT_W];
            in_now_reg      <= s_tdata[PCT_W+1 +: TIME_W];
        end
    end

    // filter state update as a sample moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_percent_reg     <= '0;
            percent_seen_reg     <= 1'b0;
            last_charging_reg    <= 1'b0;
            charging_seen_reg    <= 1'b0;
            last_report_time_reg <= '0;
        end else if (advance) begin
            if (charge_change) begin
                charging_seen_reg <= 1'b1;
                last_charging_reg <= in_charging_reg;
            end
            if (reason != REASON_NONE) begin
                percent_seen_reg     <= 1'b1;
                last_percent_reg     <= in_percent_reg;
                last_report_time_reg <= in_now_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // the first sample after reset always reports both the percentage and the flag
    a_first_report: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !percent_seen_reg |=>
            result_reg.report_reason == REASON_FIRST && result_reg.pct_report &&
            result_reg.charge_report)
        else $error("first sample did not report");

    // percentage flag and reason agree, and value is zero when nothing is reported
    a_pct_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            (result_reg.pct_report == (result_reg.report_reason != REASON_NONE)) &&
            (result_reg.pct_report || result_reg.pct_value == '0))
        else $error("percentage report fields disagree");

    // a result only appears for a sample held in the input register
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a sample");

    // a reported percentage becomes the new reference
    a_state_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && reason != REASON_NONE |=>
            last_percent_reg == result_reg.pct_value && percent_seen_reg)
        else $error("reference percentage not updated");

endmodule
